FILE: hdl/cdn_pkg.sv
// cdn_pkg: shared types, constants and the month-length function for the
// calendar date/time normalizer; no dependencies
`default_nettype none

package cdn_pkg;

    // time unit constants
    localparam int unsigned US_PER_SEC      = 1000000;
    localparam int unsigned SEC_PER_MIN     = 60;
    localparam int unsigned MIN_PER_HOUR    = 60;
    localparam int unsigned HOUR_PER_DAY    = 24;
    localparam int unsigned MONTHS_PER_YEAR = 12;

    // microsecond stage: reciprocal multiply fed ten dividend bits per pass
    localparam int unsigned DIV_STEPS  = 4;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned US_CHUNK_W = 10;
    localparam int unsigned US_SHIFT   = 60;
    localparam logic [40:0] US_RECIP   = 41'd1152921504607;

    // reciprocals for the small carry stages, exact for operands below 2^21
    localparam logic [21:0] RECIP_BY_60 = 22'd2236963;
    localparam int unsigned SHIFT_BY_60 = 27;
    localparam logic [21:0] RECIP_BY_24 = 22'd2796203;
    localparam int unsigned SHIFT_BY_24 = 26;
    localparam logic [21:0] RECIP_BY_12 = 22'd2796203;
    localparam int unsigned SHIFT_BY_12 = 25;

    // cumulative days before each month, non-leap year
    localparam logic [8:0] CUM_DAYS [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_DIV,
        S_RUN_DIV,
        S_STORE_DIV,
        S_WALK,
        S_OUT
    } t_state;

    // which carry stage the shared divider is working on
    typedef enum logic [2:0] {
        OP_US,
        OP_SEC,
        OP_MIN,
        OP_HR,
        OP_MON
    } t_div_op;

    // controller to datapath commands
    typedef struct packed {
        logic    load_in;
        logic    div_load;
        logic    div_step;
        logic    div_store;
        t_div_op op;
        logic    walk_step;
        logic    out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic walk_done;
    } t_dp_sts;

    // days in a month; out-of-range month reads as january
    function automatic logic [4:0] cdn_month_len(input logic [3:0] mon, input logic leap);
        logic [3:0] m;
        logic [8:0] diff;
        m = (mon >= 4'd1 && mon <= 4'(MONTHS_PER_YEAR)) ? mon : 4'd1;
        diff = CUM_DAYS[m] - CUM_DAYS[m - 4'd1];
        if (m == 4'd2 && leap) begin
            diff = diff + 9'd1;
        end
        return diff[4:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cdn_in_if.sv
// cdn_in_if: input channel of the normalizer, valid/ready plus the raw
// date and time fields; no dependencies
`default_nettype none

interface cdn_in_if;
    logic        valid;
    logic        ready;
    logic [13:0] year_in;
    logic [7:0]  month_in;
    logic [15:0] day_in;
    logic [7:0]  hours_in;
    logic [7:0]  minutes_in;
    logic [7:0]  seconds_in;
    logic [39:0] micros_in;

    modport source (
        output valid, year_in, month_in, day_in, hours_in, minutes_in,
               seconds_in, micros_in,
        input  ready
    );
    modport sink (
        input  valid, year_in, month_in, day_in, hours_in, minutes_in,
               seconds_in, micros_in,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/cdn_out_if.sv
// cdn_out_if: result channel of the normalizer, valid/ready plus the
// normalized date and time fields; no dependencies
`default_nettype none

interface cdn_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [19:0] micros_out;

    modport source (
        output valid, year_out, month_out, day_out, hour_out, minute_out,
               second_out, micros_out,
        input  ready
    );
    modport sink (
        input  valid, year_out, month_out, day_out, hour_out, minute_out,
               second_out, micros_out,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/cdn_dp.sv
// cdn_dp: datapath of the normalizer: input capture, reciprocal-multiply
// carry chain, month walk and result register; uses cdn_pkg
`default_nettype none

module cdn_dp (
    input  wire logic            i_clk,
    input  wire cdn_pkg::t_dp_cmd i_cmd,
    output cdn_pkg::t_dp_sts     o_sts,
    input  wire logic [13:0]     i_year_in,
    input  wire logic [7:0]      i_month_in,
    input  wire logic [15:0]     i_day_in,
    input  wire logic [7:0]      i_hours_in,
    input  wire logic [7:0]      i_minutes_in,
    input  wire logic [7:0]      i_seconds_in,
    input  wire logic [39:0]     i_micros_in,
    output logic [13:0]          o_year_out,
    output logic [3:0]           o_month_out,
    output logic [4:0]           o_day_out,
    output logic [4:0]           o_hour_out,
    output logic [5:0]           o_minute_out,
    output logic [5:0]           o_second_out,
    output logic [19:0]          o_micros_out
);
    import cdn_pkg::*;

    // captured inputs
    logic [7:0]  r_hours_in;
    logic [7:0]  r_minutes_in;
    logic [7:0]  r_seconds_in;
    logic [39:0] r_micros_in;
    logic [15:0] r_day_m1;
    logic [7:0]  r_mon_m1;

    // working state
    logic [13:0] r_year;
    logic [3:0]  r_mon;
    logic [16:0] r_offset;
    logic [20:0] r_carry;
    logic [19:0] r_us;
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hr;

    // stage operand; the microsecond stage shifts it out ten bits per pass
    logic [39:0] r_dvd;
    logic [80:0] r_acc;

    logic [39:0] operand;
    logic [50:0] us_part_prod;
    logic [20:0] us_q;
    logic [19:0] us_rem;
    logic [42:0] small_prod;
    logic [20:0] small_q;
    logic [20:0] small_rem;
    logic [4:0]  cur_len;
    logic        walk_done;

    // dividend for the current carry stage
    always_comb begin
        unique case (i_cmd.op)
            OP_US: begin
                operand = r_micros_in;
            end
            OP_SEC: begin
                operand = 40'(r_carry) + 40'(r_seconds_in);
            end
            OP_MIN: begin
                operand = 40'(r_carry) + 40'(r_minutes_in);
            end
            OP_HR: begin
                operand = 40'(r_carry) + 40'(r_hours_in);
            end
            OP_MON: begin
                operand = 40'(r_mon_m1);
            end
            default: begin
                operand = r_micros_in;
            end
        endcase
    end

    // microsecond quotient and remainder from the accumulated product
    assign us_part_prod = 51'(r_dvd[39 -: US_CHUNK_W]) * 51'(US_RECIP);
    assign us_q         = r_acc[US_SHIFT +: 21];
    assign us_rem       = r_micros_in[19:0] - 20'(us_q * 20'(US_PER_SEC));

    // small stages: one reciprocal multiply and a remainder
    always_comb begin
        unique case (i_cmd.op)
            OP_SEC, OP_MIN: begin
                small_prod = 43'(r_dvd[20:0]) * 43'(RECIP_BY_60);
                small_q    = 21'(small_prod >> SHIFT_BY_60);
                small_rem  = r_dvd[20:0] - 21'(small_q * 21'(SEC_PER_MIN));
            end
            OP_HR: begin
                small_prod = 43'(r_dvd[20:0]) * 43'(RECIP_BY_24);
                small_q    = 21'(small_prod >> SHIFT_BY_24);
                small_rem  = r_dvd[20:0] - 21'(small_q * 21'(HOUR_PER_DAY));
            end
            OP_MON: begin
                small_prod = 43'(r_dvd[20:0]) * 43'(RECIP_BY_12);
                small_q    = 21'(small_prod >> SHIFT_BY_12);
                small_rem  = r_dvd[20:0] - 21'(small_q * 21'(MONTHS_PER_YEAR));
            end
            default: begin
                small_prod = '0;
                small_q    = '0;
                small_rem  = '0;
            end
        endcase
    end

    // month walk compare
    assign cur_len         = cdn_month_len(r_mon, r_year[1:0] == 2'b00);
    assign walk_done       = r_offset < 17'(cur_len);
    assign o_sts.walk_done = walk_done;

    // input capture with month and day zero taken as one
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_hours_in   <= i_hours_in;
            r_minutes_in <= i_minutes_in;
            r_seconds_in <= i_seconds_in;
            r_micros_in  <= i_micros_in;
            r_day_m1     <= (i_day_in == 16'd0) ? 16'd0 : i_day_in - 16'd1;
            r_mon_m1     <= (i_month_in == 8'd0) ? 8'd0 : i_month_in - 8'd1;
        end
    end

    // operand register and microsecond product accumulation, top chunk first
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd <= operand;
            r_acc <= '0;
        end else if (i_cmd.div_step && i_cmd.op == OP_US) begin
            r_dvd <= r_dvd << US_CHUNK_W;
            r_acc <= (r_acc << US_CHUNK_W) + 81'(us_part_prod);
        end
    end

    // carry chain results and month walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_year <= i_year_in;
        end else if (i_cmd.div_store) begin
            unique case (i_cmd.op)
                OP_US: begin
                    r_us    <= us_rem;
                    r_carry <= us_q;
                end
                OP_SEC: begin
                    r_sec   <= small_rem[5:0];
                    r_carry <= small_q;
                end
                OP_MIN: begin
                    r_min   <= small_rem[5:0];
                    r_carry <= small_q;
                end
                OP_HR: begin
                    r_hr     <= small_rem[4:0];
                    r_offset <= 17'(r_day_m1) + small_q[16:0];
                end
                OP_MON: begin
                    r_year <= r_year + small_q[13:0];
                    r_mon  <= small_rem[3:0] + 4'd1;
                end
                default: begin
                    r_carry <= r_dvd[20:0];
                end
            endcase
        end else if (i_cmd.walk_step) begin
            r_offset <= r_offset - 17'(cur_len);
            if (r_mon == 4'(MONTHS_PER_YEAR)) begin
                r_mon  <= 4'd1;
                r_year <= r_year + 14'd1;
            end else begin
                r_mon <= r_mon + 4'd1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_year_out   <= r_year;
            o_month_out  <= r_mon;
            o_day_out    <= r_offset[4:0] + 5'd1;
            o_hour_out   <= r_hr;
            o_minute_out <= r_min;
            o_second_out <= r_sec;
            o_micros_out <= r_us;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cdn_ctrl.sv
// cdn_ctrl: controller of the normalizer: sequences the divider stages and
// the month walk, owns the channel handshakes; uses cdn_pkg
`default_nettype none

module cdn_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output cdn_pkg::t_dp_cmd      o_cmd,
    input  wire cdn_pkg::t_dp_sts i_sts
);
    import cdn_pkg::*;

    t_state               r_state, n_state;
    t_div_op              r_op, n_op;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD_DIV;
                end
            end
            S_LOAD_DIV: begin
                n_state = S_RUN_DIV;
            end
            S_RUN_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_STORE_DIV;
                end
            end
            S_STORE_DIV: begin
                n_state = (r_op == OP_MON) ? S_WALK : S_LOAD_DIV;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // stage select and step counter
    always_comb begin
        n_op  = r_op;
        n_cnt = r_cnt;
        if (r_state == S_IDLE) begin
            n_op = OP_US;
        end else if (r_state == S_STORE_DIV) begin
            unique case (r_op)
                OP_US:   n_op = OP_SEC;
                OP_SEC:  n_op = OP_MIN;
                OP_MIN:  n_op = OP_HR;
                OP_HR:   n_op = OP_MON;
                OP_MON:  n_op = OP_MON;
                default: n_op = OP_US;
            endcase
        end
        if (r_state == S_LOAD_DIV) begin
            n_cnt = '0;
        end else if (r_state == S_RUN_DIV) begin
            n_cnt = r_cnt + DIV_CNT_W'(1);
        end
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_OUT && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // command outputs
    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_cmd.load_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_load  = (r_state == S_LOAD_DIV);
        o_cmd.div_step  = (r_state == S_RUN_DIV);
        o_cmd.div_store = (r_state == S_STORE_DIV);
        o_cmd.op        = r_op;
        o_cmd.walk_step = (r_state == S_WALK) && !i_sts.walk_done;
        o_cmd.out_load  = (r_state == S_OUT) && out_free;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_US;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // an accepted transaction starts the microsecond stage
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_LOAD_DIV && r_op == OP_US))
        else $error("accepted transaction did not start the divider");

    // a new result is only loaded when the result register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while still held");

    // the month walk only begins after the month stage
    a_walk_after_mon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && $past(r_state) != S_WALK) |-> (r_op == OP_MON))
        else $error("month walk entered before the month stage");

    // each result load raises valid on the next cycle
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("result loaded without valid");
`endif

endmodule

`default_nettype wire

FILE: hdl/calendar_datetime_normalizer.sv
// calendar_datetime_normalizer: one transaction at a time through five carry stages
// (microseconds by a four-pass reciprocal multiply, the rest by a single reciprocal
// multiply) and a month walk of one month per cycle.
// the month walk covers 0 to about 2155 months and sets the worst case per transaction
// reset: synchronous active-low i_rst_n clears controller state and result valid
`default_nettype none

module calendar_datetime_normalizer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cdn_in_if.sink    i_in,
    cdn_out_if.source o_out
);
    import cdn_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    cdn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // arithmetic
    cdn_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_year_in    (i_in.year_in),
        .i_month_in   (i_in.month_in),
        .i_day_in     (i_in.day_in),
        .i_hours_in   (i_in.hours_in),
        .i_minutes_in (i_in.minutes_in),
        .i_seconds_in (i_in.seconds_in),
        .i_micros_in  (i_in.micros_in),
        .o_year_out   (o_out.year_out),
        .o_month_out  (o_out.month_out),
        .o_day_out    (o_out.day_out),
        .o_hour_out   (o_out.hour_out),
        .o_minute_out (o_out.minute_out),
        .o_second_out (o_out.second_out),
        .o_micros_out (o_out.micros_out)
    );

endmodule

`default_nettype wire

FILE: dv/calendar_datetime_normalizer_test.sv
// calendar_datetime_normalizer_test: self-checking bench for the date/time normalizer,
// with a directed table followed by random transactions, checked against its own predictor
// depends on cdn_pkg, cdn_in_if, cdn_out_if and calendar_datetime_normalizer
module calendar_datetime_normalizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdn_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 250;
    localparam int DRAIN_CYCLES  = 2500;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int REPORT_LIMIT  = 10;

    // days per month, non-leap
    localparam int unsigned MONTH_DAYS [0:11] = '{
        31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };

    typedef struct packed {
        logic [13:0] year;
        logic [7:0]  month;
        logic [15:0] day;
        logic [7:0]  hours;
        logic [7:0]  minutes;
        logic [7:0]  seconds;
        logic [39:0] micros;
    } raw_datetime_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] micros;
    } norm_datetime_t;

    typedef struct {
        raw_datetime_t  stim;
        bit             typed;
        norm_datetime_t want;
    } date_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdn_in_if  u_in_if ();
    cdn_out_if u_out_if ();

    calendar_datetime_normalizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    norm_datetime_t pending_dates [$];
    date_row_t      date_table [$];
    int unsigned    cycle_cnt      = 0;
    int unsigned    mismatch_cnt   = 0;
    int unsigned    results_checked = 0;
    int unsigned    directed_sent  = 0;
    int unsigned    random_sent    = 0;
    int unsigned    long_walks     = 0;

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // carry chain, then month-by-month walk of the surplus days
    function automatic norm_datetime_t normalize_datetime(input raw_datetime_t it);
        longint unsigned carry;
        longint unsigned t;
        longint unsigned offset;
        int unsigned     yr;
        int unsigned     mon;
        int unsigned     mlen;
        norm_datetime_t  r;
        r.micros = 20'(it.micros % US_PER_SEC);
        carry    = it.micros / US_PER_SEC;
        t        = it.seconds + carry;
        r.second = 6'(t % SEC_PER_MIN);
        carry    = t / SEC_PER_MIN;
        t        = it.minutes + carry;
        r.minute = 6'(t % MIN_PER_HOUR);
        carry    = t / MIN_PER_HOUR;
        t        = it.hours + carry;
        r.hour   = 5'(t % HOUR_PER_DAY);
        carry    = t / HOUR_PER_DAY;
        // zero month and zero day both saturate up to one
        mon    = (it.month == 0) ? 1 : it.month;
        offset = ((it.day == 0) ? 0 : it.day - 1) + carry;
        yr     = it.year + (mon - 1) / MONTHS_PER_YEAR;
        mon    = (mon - 1) % MONTHS_PER_YEAR + 1;
        forever begin
            mlen = MONTH_DAYS[mon - 1] + ((mon == 2 && yr % 4 == 0) ? 1 : 0);
            if (offset < mlen) begin
                break;
            end
            offset = offset - mlen;
            mon++;
            if (mon > MONTHS_PER_YEAR) begin
                mon = 1;
                yr++;
            end
        end
        r.year  = 14'(yr);
        r.month = 4'(mon);
        r.day   = 5'(offset + 1);
        return r;
    endfunction

    task automatic note_fail(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    function automatic string show_date(input norm_datetime_t d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d", d.year, d.month, d.day,
                         d.hour, d.minute, d.second, d.micros);
    endfunction

    // one input transaction; waits for the handshake, then queues its expectation
    task automatic send_date(input raw_datetime_t it, input bit typed,
                             input norm_datetime_t want);
        u_in_if.valid      = 1'b1;
        u_in_if.year_in    = it.year;
        u_in_if.month_in   = it.month;
        u_in_if.day_in     = it.day;
        u_in_if.hours_in   = it.hours;
        u_in_if.minutes_in = it.minutes;
        u_in_if.seconds_in = it.seconds;
        u_in_if.micros_in  = it.micros;
        do begin
            @(posedge i_clk);
        end while (!u_in_if.ready);
        pending_dates.push_back(typed ? want : normalize_datetime(it));
        if (it.day > 16'd32767) begin
            long_walks++;
        end
        @(negedge i_clk);
    endtask

    // sender idle time: mostly none or short, sometimes long
    task automatic sender_gap();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(99);
        if (pick < 60) begin
            gap = 0;
        end else if (pick < 90) begin
            gap = $urandom_range(3, 1);
        end else begin
            gap = $urandom_range(400, 20);
        end
        if (gap != 0) begin
            u_in_if.valid      = 1'b0;
            u_in_if.year_in    = 14'($urandom);
            u_in_if.day_in     = 16'($urandom);
            u_in_if.micros_in  = {8'($urandom), $urandom};
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic add_row(input raw_datetime_t stim, input bit typed,
                           input norm_datetime_t want);
        date_row_t row;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        date_table.push_back(row);
    endtask

    // random transaction, mixing small and long walks with some full-range fields
    function automatic raw_datetime_t random_date();
        raw_datetime_t it;
        int unsigned   pick;
        pick = $urandom_range(99);
        it.year = (pick < 60) ? 14'($urandom_range(9999)) :
                  (pick < 90) ? 14'($urandom) : 14'($urandom_range(16383, 16300));
        pick = $urandom_range(99);
        it.month = (pick < 60) ? 8'($urandom_range(12)) : 8'($urandom);
        pick = $urandom_range(99);
        it.day = (pick < 45) ? 16'($urandom_range(400)) :
                 (pick < 85) ? 16'($urandom) :
                 (pick < 95) ? 16'($urandom_range(65535, 60000)) : 16'd0;
        pick = $urandom_range(99);
        if (pick < 50) begin
            it.hours   = 8'($urandom_range(23));
            it.minutes = 8'($urandom_range(59));
            it.seconds = 8'($urandom_range(59));
        end else begin
            it.hours   = 8'($urandom);
            it.minutes = 8'($urandom);
            it.seconds = 8'($urandom);
        end
        pick = $urandom_range(99);
        it.micros = (pick < 40) ? 40'($urandom_range(999999)) :
                    (pick < 80) ? {8'($urandom), $urandom} : 40'($urandom_range(100000000));
        return it;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        norm_datetime_t got;
        norm_datetime_t want;
        if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
            got.year   = u_out_if.year_out;
            got.month  = u_out_if.month_out;
            got.day    = u_out_if.day_out;
            got.hour   = u_out_if.hour_out;
            got.minute = u_out_if.minute_out;
            got.second = u_out_if.second_out;
            got.micros = u_out_if.micros_out;
            if (pending_dates.size() == 0) begin
                note_fail($sformatf("unexpected result %s", show_date(got)));
            end else begin
                want = pending_dates.pop_front();
                results_checked++;
                if (got.year !== want.year || got.month !== want.month ||
                    got.day !== want.day || got.hour !== want.hour ||
                    got.minute !== want.minute || got.second !== want.second ||
                    got.micros !== want.micros) begin
                    note_fail($sformatf("result %0d: expected %s, got %s",
                              results_checked, show_date(want), show_date(got)));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_dates.size());
            $display("calendar_datetime_normalizer_test: FAIL");
            $finish;
        end
    end

    // receiver backpressure: short stalls, rare long ones, and stall-free stretches
    initial begin
        int unsigned hold;
        int unsigned pick;
        hold = 0;
        u_out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold != 0) begin
                hold--;
            end else begin
                pick = $urandom_range(99);
                if (pick < 2) begin
                    u_out_if.ready = 1'b1;
                    hold = $urandom_range(3000, 300);
                end else if (pick < 70) begin
                    u_out_if.ready = 1'b1;
                    hold = $urandom_range(20);
                end else if (pick < 95) begin
                    u_out_if.ready = 1'b0;
                    hold = $urandom_range(3);
                end else begin
                    u_out_if.ready = 1'b0;
                    hold = $urandom_range(150, 20);
                end
            end
        end
    end

    // reset, directed table, random transactions, drain
    initial begin
        raw_datetime_t  it;
        norm_datetime_t none;
        none = '0;
        i_rst_n            = 1'b0;
        u_in_if.valid      = 1'b0;
        u_in_if.year_in    = '0;
        u_in_if.month_in   = '0;
        u_in_if.day_in     = '0;
        u_in_if.hours_in   = '0;
        u_in_if.minutes_in = '0;
        u_in_if.seconds_in = '0;
        u_in_if.micros_in  = '0;

        // directed table: year, month, day, hours, minutes, seconds, micros
        add_row(raw_datetime_t'{14'd0, 8'd1, 16'd1, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0});
        // zero month and zero day
        add_row(raw_datetime_t'{14'd5, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd5, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0});
        add_row(raw_datetime_t'{14'd2001, 8'd1, 16'd1, 8'd0, 8'd0, 8'd0, 40'hFF_FFFF_FFFF}, 1,
                norm_datetime_t'{14'd2001, 4'd1, 5'd13, 5'd17, 6'd25, 6'd11, 20'd627775});
        add_row(raw_datetime_t'{14'd2001, 8'd1, 16'd1, 8'd255, 8'd255, 8'd255,
                40'hFF_FFFF_FFFF}, 1,
                norm_datetime_t'{14'd2001, 4'd1, 5'd24, 5'd12, 6'd44, 6'd26, 20'd627775});
        add_row(raw_datetime_t'{14'd2020, 8'd6, 16'd15, 8'd0, 8'd0, 8'd0, 40'd999999}, 1,
                norm_datetime_t'{14'd2020, 4'd6, 5'd15, 5'd0, 6'd0, 6'd0, 20'd999999});
        add_row(raw_datetime_t'{14'd2020, 8'd6, 16'd15, 8'd0, 8'd0, 8'd0, 40'd1000000}, 1,
                norm_datetime_t'{14'd2020, 4'd6, 5'd15, 5'd0, 6'd0, 6'd1, 20'd0});
        // carry ripples all the way into a new year
        add_row(raw_datetime_t'{14'd2023, 8'd12, 16'd31, 8'd23, 8'd59, 8'd60, 40'd0}, 1,
                norm_datetime_t'{14'd2024, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0});
        add_row(raw_datetime_t'{14'd1999, 8'd13, 16'd1, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0});
        add_row(raw_datetime_t'{14'd100, 8'd255, 16'd1, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd121, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0});
        // leap and non-leap february
        add_row(raw_datetime_t'{14'd2000, 8'd2, 16'd29, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 20'd0});
        add_row(raw_datetime_t'{14'd2001, 8'd2, 16'd29, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd2001, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0});
        add_row(raw_datetime_t'{14'd1900, 8'd2, 16'd29, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd1900, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 20'd0});
        // year wraps past the top of its field
        add_row(raw_datetime_t'{14'd16383, 8'd12, 16'd32, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0});
        add_row(raw_datetime_t'{14'd16383, 8'd14, 16'd29, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd0, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 20'd0});
        add_row(raw_datetime_t'{14'd9999, 8'd12, 16'd31, 8'd23, 8'd59, 8'd59, 40'd999999}, 1,
                norm_datetime_t'{14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 20'd999999});
        add_row(raw_datetime_t'{14'd2004, 8'd1, 16'd366, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd2004, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 20'd0});
        add_row(raw_datetime_t'{14'd2003, 8'd1, 16'd366, 8'd0, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd2004, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 20'd0});
        add_row(raw_datetime_t'{14'd2010, 8'd3, 16'd10, 8'd255, 8'd0, 8'd0, 40'd0}, 1,
                norm_datetime_t'{14'd2010, 4'd3, 5'd20, 5'd15, 6'd0, 6'd0, 20'd0});
        // longest walks and a time-field carry near the top year, predicted
        add_row(raw_datetime_t'{14'd0, 8'd1, 16'd65535, 8'd0, 8'd0, 8'd0, 40'd0}, 0, none);
        add_row(raw_datetime_t'{14'd16383, 8'd255, 16'd65535, 8'd255, 8'd255, 8'd255,
                40'hFF_FFFF_FFFF}, 0, none);
        add_row(raw_datetime_t'{14'd9999, 8'd12, 16'd65535, 8'd23, 8'd59, 8'd59,
                40'd999999}, 0, none);
        add_row(raw_datetime_t'{14'd16380, 8'd0, 16'd0, 8'd24, 8'd60, 8'd60, 40'd0}, 0, none);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (date_table[i]) begin
            send_date(date_table[i].stim, date_table[i].typed, date_table[i].want);
            directed_sent++;
            sender_gap();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // hold off once until the pipeline is empty
            if (n == RANDOM_ITEMS / 2) begin
                u_in_if.valid = 1'b0;
                while (pending_dates.size() != 0) @(negedge i_clk);
            end
            it = random_date();
            send_date(it, 1'b0, none);
            random_sent++;
            sender_gap();
        end
        u_in_if.valid = 1'b0;

        while (pending_dates.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d directed and %0d random transactions, %0d results checked",
                 directed_sent, random_sent, results_checked);
        $display("%0d transactions walked more than 32767 days, %0d mismatches in %0d cycles",
                 long_walks, mismatch_cnt, cycle_cnt);
        if (mismatch_cnt == 0 && pending_dates.size() == 0) begin
            $display("calendar_datetime_normalizer_test: PASS");
        end else begin
            $display("calendar_datetime_normalizer_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/cdn_pkg.sv
hdl/cdn_in_if.sv
hdl/cdn_out_if.sv
hdl/cdn_dp.sv
hdl/cdn_ctrl.sv
hdl/calendar_datetime_normalizer.sv
dv/calendar_datetime_normalizer_test.sv
